@@ sv/priority_interrupt_dispatcher_macros.svh @@
// assertion macros shared by the dispatcher rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef PRIORITY_INTERRUPT_DISPATCHER_MACROS_SVH
`define PRIORITY_INTERRUPT_DISPATCHER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PID_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// next-cycle implication
`define PID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define PID_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PID_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/pid_pkg.sv @@
// shared types and codes for the priority interrupt dispatcher
// no dependencies
package pid_pkg;

   localparam int OP_W    = 3;
   localparam int IRQ_W   = 8;
   localparam int CLS_W   = 2;
   localparam int CNT_W   = 32;
   localparam int CLS_NUM = 4;

   localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
   localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
   localparam logic [OP_W-1:0] OP_RAISE      = 3'd2;
   localparam logic [OP_W-1:0] OP_BATCH      = 3'd3;
   localparam logic [OP_W-1:0] OP_ADD        = 3'd4;
   localparam logic [OP_W-1:0] OP_NEXT       = 3'd5;
   localparam logic [OP_W-1:0] OP_READ       = 3'd6;
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

   localparam logic [CLS_W-1:0] CLS_HIGH   = 2'd0;
   localparam logic [CLS_W-1:0] CLS_NORMAL = 2'd1;
   localparam logic [CLS_W-1:0] CLS_LOW    = 2'd2;
   localparam logic [CLS_W-1:0] CLS_OTHER  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [IRQ_W-1:0] irq_number;
      logic [CLS_W-1:0] priority_class;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [IRQ_W-1:0] dispatched_irq;
      logic             dispatch_valid;
      logic             had_handler;
      logic [CNT_W-1:0] event_count;
      logic [CNT_W-1:0] processed_total;
      logic [CNT_W-1:0] high_added;
      logic [CNT_W-1:0] normal_added;
      logic [CNT_W-1:0] low_added;
   } rsp_type;

   // one line table entry
   typedef struct packed {
      logic             registered;
      logic [CLS_W-1:0] cls;
      logic [CNT_W-1:0] count;
   } line_entry_type;

   // controller to pending set
   typedef struct packed {
      logic             clear_all;
      logic             set_en;
      logic             move_en;
      logic             drop_en;
      logic             scan1;
      logic             scan2;
      logic             mode;
      logic [CLS_W-1:0] cls;
   } pend_cmd_type;

endpackage

@@ sv/priority_interrupt_dispatcher.sv @@
// priority interrupt dispatcher top level: command decode, line table, batch counters
// depends on pid_pkg, pid_ram, pid_pend and priority_interrupt_dispatcher_macros.svh
//
// channel    ports                   transfer
// request    start, busy, req_word   word taken when start && !busy
// response   rsp_strobe, rsp_word    word valid for one cycle, no back-pressure
// config     csr_we, csr_wdata       dispatch mode written when csr_we
//
// next goes through two registered search stages over the pending set, one
// table read and one read-modify-write before the next accept.
// all other commands take a table read, then a read-modify-write.
// the response word strobes in the cycle after the write-back; a new word
// may be taken in that same cycle.
// after reset the line table is cleared one entry a cycle with busy high;
// csr writes are taken during that pass.
`include "priority_interrupt_dispatcher_macros.svh"

module priority_interrupt_dispatcher import pid_pkg::*; #(
   parameter int NUM_LINES = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   localparam int IDX_W   = $clog2(NUM_LINES);
   localparam int EXT_W   = (IDX_W + 1 > IRQ_W) ? IDX_W + 1 : IRQ_W + 1;
   localparam int ENTRY_W = $bits(line_entry_type);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SCAN1 = 6'b000100,
      ST_SCAN2 = 6'b001000,
      ST_FETCH = 6'b010000,
      ST_EXEC  = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic             ok_ff, ok_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic             mode_ff, mode_in;
   logic [CNT_W-1:0] proc_ff, proc_in;
   logic [CNT_W-1:0] high_ff, high_in;
   logic [CNT_W-1:0] normal_ff, normal_in;
   logic [CNT_W-1:0] low_ff, low_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   line_entry_type   ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   line_entry_type   entry;
   logic [IDX_W-1:0] req_idx;

   pend_cmd_type     pcmd;
   logic [IDX_W-1:0] pidx;
   logic             pfound;
   logic [IDX_W-1:0] ppick;

   assign entry   = line_entry_type'(ram_rdata);
   assign req_idx = IDX_W'(req_ff.irq_number);

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      ok_in         = ok_ff;
      clr_idx_in    = clr_idx_ff;
      mode_in       = csr_we ? csr_wdata : mode_ff;
      proc_in       = proc_ff;
      high_in       = high_ff;
      normal_in     = normal_ff;
      low_in        = low_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = req_idx;
      ram_wdata     = entry;
      ram_raddr     = IDX_W'(req_word.irq_number);
      pcmd          = '0;
      pcmd.mode     = mode_ff;
      pidx          = req_idx;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we               = 1'b1;
            ram_waddr            = clr_idx_ff;
            ram_wdata.registered = 1'b0;
            ram_wdata.cls        = CLS_OTHER;
            ram_wdata.count      = '0;
            clr_idx_in           = clr_idx_ff + IDX_W'(1);
            if (clr_idx_ff == IDX_W'(NUM_LINES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               req_in   = req_word;
               ok_in    = EXT_W'(req_word.irq_number) < EXT_W'(NUM_LINES);
               state_in = (req_word.opcode == OP_NEXT) ? ST_SCAN1 : ST_EXEC;
            end
         end
         ST_SCAN1: begin
            pcmd.scan1 = 1'b1;
            state_in   = ST_SCAN2;
         end
         ST_SCAN2: begin
            pcmd.scan2 = 1'b1;
            state_in   = ST_FETCH;
         end
         ST_FETCH: begin
            ram_raddr = ppick;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            rsp_in        = '0;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
            unique case (req_ff.opcode)
               OP_REGISTER: begin
                  if (!ok_ff || entry.registered) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     ram_we               = 1'b1;
                     ram_wdata.registered = 1'b1;
                     ram_wdata.cls        = req_ff.priority_class;
                     ram_wdata.count      = '0;
                     pcmd.move_en         = 1'b1;
                     pcmd.cls             = req_ff.priority_class;
                  end
               end
               OP_UNREGISTER: begin
                  if (ok_ff && entry.registered) begin
                     ram_we               = 1'b1;
                     ram_wdata.registered = 1'b0;
                     ram_wdata.cls        = CLS_OTHER;
                     ram_wdata.count      = '0;
                     pcmd.move_en         = 1'b1;
                     pcmd.cls             = CLS_OTHER;
                  end
               end
               OP_RAISE: begin
                  if (ok_ff && entry.registered) begin
                     ram_we             = 1'b1;
                     ram_wdata.count    = entry.count + CNT_W'(1);
                     rsp_in.had_handler = 1'b1;
                  end
               end
               OP_BATCH: begin
                  pcmd.clear_all = 1'b1;
                  proc_in        = '0;
                  high_in        = '0;
                  normal_in      = '0;
                  low_in         = '0;
               end
               OP_ADD: begin
                  if (ok_ff) begin
                     pcmd.set_en = 1'b1;
                     pcmd.cls    = entry.cls;
                     case (entry.cls)
                        CLS_HIGH:   high_in   = high_ff + CNT_W'(1);
                        CLS_NORMAL: normal_in = normal_ff + CNT_W'(1);
                        CLS_LOW:    low_in    = low_ff + CNT_W'(1);
                        default:    ;
                     endcase
                  end
               end
               OP_NEXT: begin
                  pidx      = ppick;
                  ram_waddr = ppick;
                  if (pfound) begin
                     pcmd.drop_en          = 1'b1;
                     proc_in               = proc_ff + CNT_W'(1);
                     rsp_in.dispatched_irq = IRQ_W'(ppick);
                     rsp_in.dispatch_valid = 1'b1;
                     if (entry.registered) begin
                        ram_we             = 1'b1;
                        ram_wdata.count    = entry.count + CNT_W'(1);
                        rsp_in.had_handler = 1'b1;
                     end
                  end
               end
               OP_READ: begin
                  if (ok_ff) begin
                     rsp_in.event_count = entry.count;
                  end
               end
               OP_CLEAR: begin
                  if (ok_ff) begin
                     ram_we          = 1'b1;
                     ram_wdata.count = '0;
                  end
               end
            endcase
            rsp_in.processed_total = proc_in;
            rsp_in.high_added      = high_in;
            rsp_in.normal_added    = normal_in;
            rsp_in.low_added       = low_in;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         mode_ff       <= 1'b0;
         proc_ff       <= '0;
         high_ff       <= '0;
         normal_ff     <= '0;
         low_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         mode_ff       <= mode_in;
         proc_ff       <= proc_in;
         high_ff       <= high_in;
         normal_ff     <= normal_in;
         low_ff        <= low_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      ok_ff  <= ok_in;
      rsp_ff <= rsp_in;
   end

   pid_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_LINES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pid_pend #(
      .NUM_LINES (NUM_LINES)
   ) u_pend (
      .clock (clock),
      .reset (reset),
      .cmd   (pcmd),
      .idx   (pidx),
      .found (pfound),
      .pick  (ppick)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

   `PID_ASSERT_IMPLIES(a_rsp_after_exec, clock, reset, rsp_strobe_ff, $past(state_ff == ST_EXEC))
   `PID_ASSERT_IMPLIES(a_busy_in_clear, clock, reset, state_ff == ST_CLEAR, busy)
   `PID_ASSERT_IMPLIES(a_dispatch_word, clock, reset, rsp_strobe_ff && rsp_ff.dispatch_valid, !rsp_ff.status && rsp_ff.event_count == '0)

endmodule

@@ sv/pid_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module pid_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/pid_pend.sv @@
// pending set, one bit vector per class, with a two-stage lowest-index search
// depends on pid_pkg and priority_interrupt_dispatcher_macros.svh
`include "priority_interrupt_dispatcher_macros.svh"

module pid_pend import pid_pkg::*; #(
   parameter int NUM_LINES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pend_cmd_type                 cmd,
   input  logic [$clog2(NUM_LINES)-1:0] idx,
   output logic                         found,
   output logic [$clog2(NUM_LINES)-1:0] pick
);

   localparam int IDX_W     = $clog2(NUM_LINES);
   localparam int GRP       = 16;
   localparam int GRP_W     = $clog2(GRP);
   localparam int NUM_GRP   = (NUM_LINES + GRP - 1) / GRP;
   localparam int GRP_IDX_W = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
   localparam int PAD_W     = NUM_GRP * GRP;

   logic [NUM_LINES-1:0] pend_ff [CLS_NUM];
   logic [NUM_LINES-1:0] pend_in [CLS_NUM];
   logic [NUM_LINES-1:0] all_vec;
   logic [CLS_NUM-1:0]   cls_any;
   logic                 pend_at;

   logic                 sel_all_ff, sel_all_in;
   logic [CLS_W-1:0]     sel_cls_ff, sel_cls_in;
   logic [NUM_GRP-1:0]   grp_any_ff, grp_any_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;

   logic [PAD_W-1:0]     vec1_pad;
   logic [PAD_W-1:0]     vec2_pad;
   logic [GRP_IDX_W-1:0] grp_sel;
   logic [GRP-1:0]       grp_bits;
   logic [GRP_W-1:0]     bit_sel;

   always_comb begin
      all_vec = '0;
      pend_at = 1'b0;
      for (int c = 0; c < CLS_NUM; c++) begin
         all_vec    = all_vec | pend_ff[c];
         cls_any[c] = |pend_ff[c];
         pend_at    = pend_at | pend_ff[c][idx];
      end
   end

   // first stage: pick the vector to search and flag its non-empty groups
   always_comb begin
      sel_all_in = cmd.mode;
      sel_cls_in = CLS_OTHER;
      for (int c = CLS_NUM - 1; c >= 0; c--) begin
         if (cls_any[c]) begin
            sel_cls_in = CLS_W'(c);
         end
      end
      vec1_pad = sel_all_in ? PAD_W'(all_vec) : PAD_W'(pend_ff[sel_cls_in]);
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_any_in[g] = |vec1_pad[g*GRP +: GRP];
      end
   end

   // second stage: lowest flagged group, then lowest bit inside it
   always_comb begin
      vec2_pad = sel_all_ff ? PAD_W'(all_vec) : PAD_W'(pend_ff[sel_cls_ff]);
      grp_sel  = '0;
      for (int g = NUM_GRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            grp_sel = GRP_IDX_W'(g);
         end
      end
      grp_bits = vec2_pad[grp_sel*GRP +: GRP];
      bit_sel  = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bit_sel = GRP_W'(b);
         end
      end
      found_in = |grp_any_ff;
      pick_in  = IDX_W'({grp_sel, bit_sel});
   end

   always_comb begin
      for (int c = 0; c < CLS_NUM; c++) begin
         pend_in[c] = pend_ff[c];
      end
      if (cmd.clear_all) begin
         for (int c = 0; c < CLS_NUM; c++) begin
            pend_in[c] = '0;
         end
      end else if (cmd.set_en) begin
         pend_in[cmd.cls][idx] = 1'b1;
      end else if (cmd.move_en || cmd.drop_en) begin
         // class change carries the pending bit to the new class vector; a drop clears it
         for (int c = 0; c < CLS_NUM; c++) begin
            pend_in[c][idx] = 1'b0;
         end
         if (cmd.move_en) begin
            pend_in[cmd.cls][idx] = pend_at;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CLS_NUM; c++) begin
            pend_ff[c] <= '0;
         end
         found_ff <= 1'b0;
      end else begin
         for (int c = 0; c < CLS_NUM; c++) begin
            pend_ff[c] <= pend_in[c];
         end
         if (cmd.scan2) begin
            found_ff <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan1) begin
         sel_all_ff <= sel_all_in;
         sel_cls_ff <= sel_cls_in;
         grp_any_ff <= grp_any_in;
      end
      if (cmd.scan2) begin
         pick_ff <= pick_in;
      end
   end

   assign found = found_ff;
   assign pick  = pick_ff;

   `PID_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear_all, !(|all_vec))
   `PID_ASSERT_NEXT(a_pick_is_pending, clock, reset, cmd.scan2, !found_ff || all_vec[pick_ff])
   `PID_ASSERT_IMPLIES(a_single_update, clock, reset, cmd.clear_all, !cmd.set_en && !cmd.move_en && !cmd.drop_en)

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for priority_interrupt_dispatcher: command words in, response words out
// depends on pid_pkg and the dispatcher rtl; holds its own line table and pending set model
`timescale 1ns / 100ps

module tb_top import pid_pkg::*; ();

   localparam int LINE_COUNT = 256;
   localparam int RAND_PHASES = 6;
   localparam int WORDS_PER_PHASE = 305;

   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;
   logic    csr_we;
   logic    csr_wdata;

   // typed expectation travels with the word it belongs to
   bit      row_typed;
   rsp_type row_want;

   // model of the line table, pending set and batch counters
   bit               line_taken [LINE_COUNT];
   logic [CLS_W-1:0] line_cls   [LINE_COUNT];
   logic [CNT_W-1:0] line_cnt   [LINE_COUNT];
   bit               line_pend  [LINE_COUNT];
   logic [CNT_W-1:0] done_total;
   logic [CNT_W-1:0] high_total;
   logic [CNT_W-1:0] normal_total;
   logic [CNT_W-1:0] low_total;
   bit               mode_now;

   rsp_type     rsp_due_q [$];
   dir_row_type dir_rows [$];
   rsp_type     predicted;
   int          errors;
   int          words_taken;
   int          dispatches;
   int          mode_writes;
   logic [IRQ_W-1:0] hot_base;

   priority_interrupt_dispatcher #(
      .NUM_LINES (LINE_COUNT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // applies one command to the model and returns the response word it gives
   function automatic rsp_type apply_command(input req_type cmd);
      rsp_type r;
      int      pick;
      int      idx;
      int      c;
      r = '0;
      pick = -1;
      case (cmd.opcode)
         OP_REGISTER: begin
            if (line_taken[cmd.irq_number]) begin
               r.status = 1'b1;
            end else begin
               line_taken[cmd.irq_number] = 1'b1;
               line_cls[cmd.irq_number] = cmd.priority_class;
               line_cnt[cmd.irq_number] = '0;
            end
         end
         OP_UNREGISTER: begin
            if (line_taken[cmd.irq_number]) begin
               line_taken[cmd.irq_number] = 1'b0;
               line_cls[cmd.irq_number] = CLS_OTHER;
               line_cnt[cmd.irq_number] = '0;
            end
         end
         OP_RAISE: begin
            if (line_taken[cmd.irq_number]) begin
               line_cnt[cmd.irq_number] += 1;
               r.had_handler = 1'b1;
            end
         end
         OP_BATCH: begin
            foreach (line_pend[i]) line_pend[i] = 1'b0;
            done_total = '0;
            high_total = '0;
            normal_total = '0;
            low_total = '0;
         end
         OP_ADD: begin
            line_pend[cmd.irq_number] = 1'b1;
            case (line_cls[cmd.irq_number])
               CLS_HIGH:   high_total += 1;
               CLS_NORMAL: normal_total += 1;
               CLS_LOW:    low_total += 1;
               default: ;
            endcase
         end
         OP_NEXT: begin
            if (mode_now) begin
               for (idx = 0; idx < LINE_COUNT && pick < 0; idx++)
                  if (line_pend[idx]) pick = idx;
            end else begin
               for (c = 0; c < CLS_NUM && pick < 0; c++)
                  for (idx = 0; idx < LINE_COUNT && pick < 0; idx++)
                     if (line_pend[idx] && line_cls[idx] == c[CLS_W-1:0]) pick = idx;
            end
            if (pick >= 0) begin
               line_pend[pick] = 1'b0;
               done_total += 1;
               // one count per dispatch, and only for a registered line
               if (line_taken[pick]) begin
                  line_cnt[pick] += 1;
                  r.had_handler = 1'b1;
               end
               r.dispatched_irq = pick[IRQ_W-1:0];
               r.dispatch_valid = 1'b1;
               dispatches++;
            end
         end
         OP_READ: r.event_count = line_cnt[cmd.irq_number];
         OP_CLEAR: line_cnt[cmd.irq_number] = '0;
         default: ;
      endcase
      r.processed_total = done_total;
      r.high_added = high_total;
      r.normal_added = normal_total;
      r.low_added = low_total;
      return r;
   endfunction

   function automatic req_type random_command();
      req_type cmd;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < 15)      cmd.opcode = OP_REGISTER;
      else if (roll < 21) cmd.opcode = OP_UNREGISTER;
      else if (roll < 33) cmd.opcode = OP_RAISE;
      else if (roll < 37) cmd.opcode = OP_BATCH;
      else if (roll < 62) cmd.opcode = OP_ADD;
      else if (roll < 84) cmd.opcode = OP_NEXT;
      else if (roll < 94) cmd.opcode = OP_READ;
      else                cmd.opcode = OP_CLEAR;
      // mostly a small window of lines so that commands meet the same lines again
      if ($urandom_range(0, 9) < 7)
         cmd.irq_number = hot_base + IRQ_W'($urandom_range(0, 15));
      else
         cmd.irq_number = IRQ_W'($urandom_range(0, 255));
      cmd.priority_class = CLS_W'($urandom_range(0, 3));
      return cmd;
   endfunction

   task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   task automatic check_rsp(input rsp_type want, input rsp_type got);
      check_field("status", CNT_W'(want.status), CNT_W'(got.status));
      check_field("dispatched_irq", CNT_W'(want.dispatched_irq), CNT_W'(got.dispatched_irq));
      check_field("dispatch_valid", CNT_W'(want.dispatch_valid), CNT_W'(got.dispatch_valid));
      check_field("had_handler", CNT_W'(want.had_handler), CNT_W'(got.had_handler));
      check_field("event_count", want.event_count, got.event_count);
      check_field("processed_total", want.processed_total, got.processed_total);
      check_field("high_added", want.high_added, got.high_added);
      check_field("normal_added", want.normal_added, got.normal_added);
      check_field("low_added", want.low_added, got.low_added);
   endtask

   // response words are checked before a new word is taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (rsp_due_q.size() == 0) begin
               $display("%0t ns: response word with none awaited, actual %p", $time, rsp_word);
               errors++;
            end else begin
               check_rsp(rsp_due_q.pop_front(), rsp_word);
            end
         end
         if (csr_we) mode_now = csr_wdata;
         if (start && !busy) begin
            predicted = apply_command(req_word);
            rsp_due_q.push_back(row_typed ? row_want : predicted);
            words_taken++;
         end
      end
   end

   task automatic drive_word(input req_type cmd, input bit typed, input rsp_type want);
      @(negedge clock);
      start <= 1'b1;
      req_word <= cmd;
      row_typed <= typed;
      row_want <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_for(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_drained();
      idle_for(1);
      while (rsp_due_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_dispatch_mode(input bit m);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
      mode_writes++;
   endtask

   task automatic put_row(input logic [OP_W-1:0] op, input logic [IRQ_W-1:0] irq,
                          input logic [CLS_W-1:0] cls, input bit typed,
                          input logic st, input logic had);
      dir_row_type row;
      row.cmd.opcode = op;
      row.cmd.irq_number = irq;
      row.cmd.priority_class = cls;
      row.typed = typed;
      row.want = '0;
      row.want.status = st;
      row.want.had_handler = had;
      dir_rows.push_back(row);
   endtask

   initial begin
      int sent;
      int burst;
      int gap;
      int k;
      bit m;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      row_typed = 1'b0;
      row_want = '0;
      errors = 0;
      words_taken = 0;
      dispatches = 0;
      mode_writes = 0;
      mode_now = 1'b0;
      done_total = '0;
      high_total = '0;
      normal_total = '0;
      low_total = '0;
      foreach (line_taken[i]) begin
         line_taken[i] = 1'b0;
         line_cls[i] = CLS_OTHER;
         line_cnt[i] = '0;
         line_pend[i] = 1'b0;
      end

      // empty table, taken line, extremes of the line number, both lines of
      // the other class, dispatch order by class then index, free-line unregister
      put_row(OP_READ,       8'd0,   CLS_HIGH,   1'b1, 1'b0, 1'b0);
      put_row(OP_NEXT,       8'd0,   CLS_HIGH,   1'b1, 1'b0, 1'b0);
      put_row(OP_REGISTER,   8'd0,   CLS_HIGH,   1'b1, 1'b0, 1'b0);
      put_row(OP_REGISTER,   8'd0,   CLS_LOW,    1'b1, 1'b1, 1'b0);
      put_row(OP_REGISTER,   8'd255, CLS_OTHER,  1'b1, 1'b0, 1'b0);
      put_row(OP_REGISTER,   8'd128, CLS_NORMAL, 1'b1, 1'b0, 1'b0);
      put_row(OP_RAISE,      8'd255, CLS_OTHER,  1'b1, 1'b0, 1'b1);
      put_row(OP_RAISE,      8'd3,   CLS_OTHER,  1'b1, 1'b0, 1'b0);
      put_row(OP_BATCH,      8'd0,   CLS_HIGH,   1'b1, 1'b0, 1'b0);
      put_row(OP_ADD,        8'd255, CLS_HIGH,   1'b1, 1'b0, 1'b0);
      put_row(OP_ADD,        8'd128, CLS_HIGH,   1'b0, 1'b0, 1'b0);
      put_row(OP_ADD,        8'd0,   CLS_LOW,    1'b0, 1'b0, 1'b0);
      put_row(OP_ADD,        8'd0,   CLS_LOW,    1'b0, 1'b0, 1'b0);
      put_row(OP_ADD,        8'd3,   CLS_NORMAL, 1'b0, 1'b0, 1'b0);
      repeat (5) put_row(OP_NEXT, 8'd0, CLS_HIGH, 1'b0, 1'b0, 1'b0);
      put_row(OP_READ,       8'd255, CLS_HIGH,   1'b0, 1'b0, 1'b0);
      put_row(OP_CLEAR,      8'd255, CLS_HIGH,   1'b0, 1'b0, 1'b0);
      put_row(OP_UNREGISTER, 8'd128, CLS_HIGH,   1'b0, 1'b0, 1'b0);
      put_row(OP_UNREGISTER, 8'd5,   CLS_HIGH,   1'b0, 1'b0, 1'b0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_dispatch_mode(1'b0);

      foreach (dir_rows[i]) drive_word(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
      wait_drained();

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         m = (phase < 4) ? !phase[0] : bit'($urandom_range(0, 1));
         set_dispatch_mode(m);
         hot_base = ($urandom_range(0, 3) == 0) ? 8'd240 : IRQ_W'($urandom_range(0, 255));
         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            for (k = 0; k < burst && sent < WORDS_PER_PHASE; k++) begin
               drive_word(random_command(), 1'b0, '0);
               sent++;
            end
            idle_for(gap);
         end
         // hold off until the block has answered everything
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("ran %0d command words, %0d of them dispatches, %0d mode writes over both modes",
               words_taken, dispatches, mode_writes);
      $display("%0d mismatches", errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d response words still awaited", rsp_due_q.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
